[design/mcerm_pkg.sv]
// Shared types and constants of the multi-channel echo ranging median core.
package mcerm_pkg;

    localparam int CH_W    = 3;   // width of the channel field
    localparam int STAMP_W = 16;
    localparam int DIST_W  = 16;
    localparam int SCALE_W = 18;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int MAX_REPORTS = 8;

    typedef enum logic [1:0] {
        ACT_ARM    = 2'd0,
        ACT_EDGE   = 2'd1,
        ACT_FINISH = 2'd2
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_MAX   = 3'd4;

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FIN_RD,
        S_FIN_UPD,
        S_FIN_OUT
    } t_state;

    typedef struct packed {
        logic            load;     // latch the accepted input item
        logic            arm;
        logic            edge_go;  // process a capture edge and emit its result
        logic            fin_rd;   // read channel window and form the product
        logic            fin_upd;  // range check and window update
        logic            fin_out;  // median and emit the channel report
        logic            last;
        logic [CH_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    ch_ok;
        logic    out_free;
    } t_status;

endpackage

[design/mcerm_ctrl.sv]
// Controller state machine: sequences arm, edge and finish items.
module mcerm_ctrl
    import mcerm_pkg::*;
#(
    parameter int NCH = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic [CH_W-1:0] r_fin_ch;
    logic fin_last;

    assign fin_last = (r_fin_ch == CH_W'(NCH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fin_ch <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_fin_ch <= '0;
            end else if (o_cmd.fin_out && !fin_last) begin
                r_fin_ch <= r_fin_ch + CH_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_status.action)
                    ACT_ARM:    n_state = S_IDLE;
                    ACT_EDGE: begin
                        if (!i_status.ch_ok || i_status.out_free) n_state = S_IDLE;
                    end
                    ACT_FINISH: n_state = S_FIN_RD;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_FIN_RD:  n_state = S_FIN_UPD;
            S_FIN_UPD: n_state = S_FIN_OUT;
            S_FIN_OUT: begin
                if (i_status.out_free) n_state = fin_last ? S_IDLE : S_FIN_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        o_cmd      = '0;
        o_cmd.ch   = r_fin_ch;
        unique case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_EXEC: begin
                o_cmd.arm     = (i_status.action == ACT_ARM);
                o_cmd.edge_go = (i_status.action == ACT_EDGE) && i_status.ch_ok
                                && i_status.out_free;
                o_cmd.last    = 1'b1;
            end
            S_FIN_RD:  o_cmd.fin_rd  = 1'b1;
            S_FIN_UPD: o_cmd.fin_upd = 1'b1;
            S_FIN_OUT: begin
                o_cmd.fin_out = i_status.out_free;
                o_cmd.last    = fin_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

[design/mcerm_datapath.sv]
// Datapath: capture state, distance scaling, median windows and the result register.
module mcerm_datapath
    import mcerm_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int WINDOW     = 3,
    parameter int TIMER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_action,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [STAMP_W-1:0]    i_stamp,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_report_kind,
    output logic [CH_W-1:0]       o_channel_out,
    output logic [15:0]           o_pulse_ticks,
    output logic                  o_pulse_ok,
    output logic [DIST_W-1:0]     o_echo_range,
    output logic [DIST_W-1:0]     o_median_range,
    output logic [COUNT_W-1:0]    o_captured_count,
    output logic                  o_all_captured,
    output logic                  o_last
);

    localparam int NCH  = (CHANNELS < MAX_REPORTS) ? CHANNELS : MAX_REPORTS;
    localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNTW = $clog2(WINDOW + 1);
    localparam int RW   = WINDOW * DIST_W;
    localparam int PW   = 16 + SCALE_W;
    localparam logic [31:0] WIDTH_SAT = 32'h0000_FFFF;

    // Configuration.
    logic [15:0]        r_width_min, r_width_max, r_dist_min, r_dist_max;
    logic [SCALE_W-1:0] r_scale;

    // Latched input item.
    logic [1:0]          r_action;
    logic [CH_W-1:0]     r_ch;
    logic [TIMER_BITS-1:0] r_stamp;

    // Per-channel capture and filter state.
    logic [TIMER_BITS-1:0] r_rise   [NCH];
    logic                  r_await  [NCH];
    logic                  r_wvalid [NCH];
    logic [15:0]           r_pw     [NCH];
    logic [SW-1:0]         r_slot   [NCH];
    logic                  r_full   [NCH];
    logic [COUNT_W-1:0]    r_done;
    logic [RW-1:0]         r_mem    [NCH];

    // Finish pipeline registers.
    logic [RW-1:0]   r_row;
    logic [PW-1:0]   r_prod;
    logic            r_ok;
    logic            r_good;
    logic [DIST_W-1:0] r_raw;
    logic [CNTW-1:0] r_cnt;

    logic            r_out_valid;

    logic [CW-1:0]   ce, cf;
    logic [TIMER_BITS-1:0] diff;
    logic [15:0]     w16;
    logic            w_ok;
    logic [COUNT_W-1:0] done_inc;
    logic [PW-1:0]   dsum;
    logic [SCALE_W-1:0] range_q;
    logic            good;
    logic [RW-1:0]   row_new;
    logic [SW-1:0]   slot_cur;
    logic            slot_wrap;
    logic [CNTW-1:0] cnt_new;
    logic [DIST_W-1:0] med;
    logic [DIST_W-1:0] filt;
    logic            out_free;

    assign ce = r_ch[CW-1:0];
    assign cf = i_cmd.ch[CW-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.action   = t_action'(r_action);
    assign o_status.ch_ok    = ({1'b0, r_ch} < (CH_W + 1)'(NCH));
    assign o_status.out_free = out_free;

    // Edge width with wrap, saturated to 16 bits for wide timers.
    assign diff     = r_stamp - r_rise[ce];
    assign w16      = (diff > TIMER_BITS'(WIDTH_SAT)) ? 16'hFFFF : 16'(diff);
    assign w_ok     = (w16 >= r_width_min) && (w16 <= r_width_max);
    assign done_inc = (r_done == '1) ? r_done : r_done + COUNT_W'(1);

    // Rounded distance and its range check.
    assign dsum    = r_prod + PW'(32768);
    assign range_q = dsum[PW-1:16];
    assign good = r_ok && (range_q != '0) && (range_q >= SCALE_W'(r_dist_min))
                  && (range_q <= SCALE_W'(r_dist_max));

    assign slot_cur  = r_slot[cf];
    assign slot_wrap = ({1'b0, slot_cur} == (SW + 1)'(WINDOW - 1));
    assign cnt_new   = (slot_wrap || r_full[cf]) ? CNTW'(WINDOW) : CNTW'(slot_cur) + CNTW'(1);

    always_comb begin
        row_new = r_row;
        for (int k = 0; k < WINDOW; k++) begin
            if (slot_cur == SW'(k)) row_new[k*DIST_W +: DIST_W] = range_q[DIST_W-1:0];
        end
    end

    // Median by rank: ties are broken by slot order so exactly one sample matches.
    always_comb begin
        logic [CNTW-1:0]   rank;
        logic [DIST_W-1:0] vj, vk;
        med = '0;
        for (int j = 0; j < WINDOW; j++) begin
            rank = '0;
            vj = r_row[j*DIST_W +: DIST_W];
            for (int k = 0; k < WINDOW; k++) begin
                vk = r_row[k*DIST_W +: DIST_W];
                if ((CNTW'(k) < r_cnt) && ((vk < vj) || ((vk == vj) && (k < j)))) begin
                    rank = rank + CNTW'(1);
                end
            end
            if ((CNTW'(j) < r_cnt) && (rank == (r_cnt >> 1))) med = vj;
        end
    end

    always_comb begin
        filt = r_good ? med : '0;
        if ((filt < r_dist_min) || (filt > r_dist_max)) filt = '0;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_min <= 16'd150;
            r_width_max <= 16'd23200;
            r_scale     <= 18'd112394;
            r_dist_min  <= 16'd200;
            r_dist_max  <= 16'd40000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH_MIN:  r_width_min <= i_cfg_data[15:0];
                CFG_WIDTH_MAX:  r_width_max <= i_cfg_data[15:0];
                CFG_DIST_SCALE: r_scale     <= i_cfg_data;
                CFG_DIST_MIN:   r_dist_min  <= i_cfg_data[15:0];
                CFG_DIST_MAX:   r_dist_max  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Item latch and finish pipeline payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_ch     <= i_channel;
            r_stamp  <= TIMER_BITS'(i_stamp);
        end
        if (i_cmd.edge_go && !r_await[ce]) begin
            r_rise[ce] <= r_stamp;
        end
        if (i_cmd.fin_rd) begin
            r_row  <= r_mem[cf];
            r_prod <= PW'(r_pw[cf]) * PW'(r_scale);
            r_ok   <= r_wvalid[cf];
        end
        if (i_cmd.fin_upd) begin
            r_good <= good;
            r_raw  <= good ? range_q[DIST_W-1:0] : '0;
            r_cnt  <= cnt_new;
            if (good) r_row <= row_new;
        end
    end

    // Window memory, one row per channel.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_upd && good) begin
            r_mem[cf] <= row_new;
        end
    end

    // Control state of the channels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_await[i]  <= 1'b0;
                r_wvalid[i] <= 1'b0;
                r_pw[i]     <= '0;
                r_slot[i]   <= '0;
                r_full[i]   <= 1'b0;
            end
            r_done <= '0;
        end else begin
            if (i_cmd.arm) begin
                for (int i = 0; i < NCH; i++) begin
                    r_await[i]  <= 1'b0;
                    r_wvalid[i] <= 1'b0;
                end
                r_done <= '0;
            end
            if (i_cmd.edge_go) begin
                if (!r_await[ce]) begin
                    r_await[ce] <= 1'b1;
                end else begin
                    r_await[ce]  <= 1'b0;
                    r_pw[ce]     <= w16;
                    r_wvalid[ce] <= w_ok;
                    r_done       <= done_inc;
                end
            end
            if (i_cmd.fin_upd) begin
                r_wvalid[cf] <= 1'b0;
                if (good) begin
                    r_slot[cf] <= slot_wrap ? '0 : slot_cur + SW'(1);
                    if (slot_wrap) r_full[cf] <= 1'b1;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.edge_go || i_cmd.fin_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_go) begin
            o_report_kind    <= KIND_EDGE;
            o_channel_out    <= r_ch;
            o_echo_range     <= '0;
            o_median_range   <= '0;
            o_last           <= 1'b1;
            if (r_await[ce]) begin
                o_pulse_ticks    <= w16;
                o_pulse_ok       <= w_ok;
                o_captured_count <= done_inc;
                o_all_captured   <= ({1'b0, done_inc} >= (COUNT_W + 1)'(CHANNELS));
            end else begin
                o_pulse_ticks    <= r_pw[ce];
                o_pulse_ok       <= r_wvalid[ce];
                o_captured_count <= r_done;
                o_all_captured   <= ({1'b0, r_done} >= (COUNT_W + 1)'(CHANNELS));
            end
        end else if (i_cmd.fin_out) begin
            o_report_kind    <= KIND_REPORT;
            o_channel_out    <= i_cmd.ch;
            o_pulse_ticks    <= r_pw[cf];
            o_pulse_ok       <= r_ok;
            o_echo_range     <= r_raw;
            o_median_range   <= filt;
            o_captured_count <= r_done;
            o_all_captured   <= ({1'b0, r_done} >= (COUNT_W + 1)'(CHANNELS));
            o_last           <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[design/multi_channel_echo_ranging_median_core.sv]
// Top level of the multi-channel echo ranging core with median filtering.
//
// Input channel (i_in_valid / o_in_stall) carries items: arm, capture edge
// (channel, 16-bit timer stamp) or finish. The result channel (o_out_valid /
// i_out_stall) carries edge acknowledgements and per-channel reports; o_last
// marks the final result of an item. A transfer happens on a rising edge with
// valid high and stall low. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must write it only while the block
// is idle, which the block itself does not enforce. The result of an edge
// item is written to the output register once that register is free. A
// finish item walks the reported channels, min(CHANNELS, 8) of them, through
// a read, update and median step each. One result waits in the output
// register while the next item is taken in. When the receiver stalls, the
// held result stays and the walk pauses before loading the next report.
// Reset restores the default limits, clears capture flags, counts and filter
// warm-up, and empties the output register.
module multi_channel_echo_ranging_median_core
    import mcerm_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int WINDOW     = 3,
    parameter int TIMER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_action,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [STAMP_W-1:0]    i_stamp,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_report_kind,
    output logic [CH_W-1:0]       o_channel_out,
    output logic [15:0]           o_pulse_ticks,
    output logic                  o_pulse_ok,
    output logic [DIST_W-1:0]     o_echo_range,
    output logic [DIST_W-1:0]     o_median_range,
    output logic [COUNT_W-1:0]    o_captured_count,
    output logic                  o_all_captured,
    output logic                  o_last
);

    localparam int NCH = (CHANNELS < MAX_REPORTS) ? CHANNELS : MAX_REPORTS;

    t_cmd    cmd;
    t_status status;

    mcerm_ctrl #(
        .NCH (NCH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mcerm_datapath #(
        .CHANNELS   (CHANNELS),
        .WINDOW     (WINDOW),
        .TIMER_BITS (TIMER_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_channel        (i_channel),
        .i_stamp          (i_stamp),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_report_kind    (o_report_kind),
        .o_channel_out    (o_channel_out),
        .o_pulse_ticks    (o_pulse_ticks),
        .o_pulse_ok       (o_pulse_ok),
        .o_echo_range     (o_echo_range),
        .o_median_range   (o_median_range),
        .o_captured_count (o_captured_count),
        .o_all_captured   (o_all_captured),
        .o_last           (o_last)
    );

endmodule

[design/mcerm_checker.sv]
// Port-level checker for the echo ranging core and its bind statement.
module mcerm_checker
    import mcerm_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_report_kind,
    input logic                 o_pulse_ok,
    input logic [DIST_W-1:0]    o_echo_range,
    input logic [DIST_W-1:0]    o_median_range,
    input logic [COUNT_W-1:0]   o_captured_count,
    input logic                 o_all_captured,
    input logic                 o_last
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // An edge acknowledgement is a single result with no distances.
    a_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_report_kind == KIND_EDGE) |->
            o_last && (o_echo_range == '0) && (o_median_range == '0))
        else $error("malformed edge acknowledgement");

    // A nonzero distance needs an accepted width.
    a_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_echo_range != '0) |-> o_pulse_ok)
        else $error("distance reported for a rejected width");

    // The all-captured flag follows the count.
    a_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_all_captured == ({1'b0, o_captured_count} >= (COUNT_W + 1)'(CHANNELS))))
        else $error("all_captured disagrees with captured_count");

endmodule

bind multi_channel_echo_ranging_median_core mcerm_checker #(
    .CHANNELS (CHANNELS)
) u_mcerm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_report_kind    (o_report_kind),
    .o_pulse_ok       (o_pulse_ok),
    .o_echo_range     (o_echo_range),
    .o_median_range   (o_median_range),
    .o_captured_count (o_captured_count),
    .o_all_captured   (o_all_captured),
    .o_last           (o_last)
);

[bench/echo_ranging_checker.sv]
// Scoreboard for the echo ranging core: mirrors its state, predicts every result and compares.
module echo_ranging_checker
    import mcerm_pkg::*;
#(
    parameter int CHANNELS = 8,
    parameter int WINDOW   = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_action,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [STAMP_W-1:0]    i_stamp,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_report_kind,
    input  logic [CH_W-1:0]       i_channel_out,
    input  logic [15:0]           i_pulse_ticks,
    input  logic                  i_pulse_ok,
    input  logic [DIST_W-1:0]     i_echo_range,
    input  logic [DIST_W-1:0]     i_median_range,
    input  logic [COUNT_W-1:0]    i_captured_count,
    input  logic                  i_all_captured,
    input  logic                  i_last,
    output int                    o_failures,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORTS = (CHANNELS < MAX_REPORTS) ? CHANNELS : MAX_REPORTS;
    localparam logic [15:0]        DEFAULT_WIDTH_MIN = 16'd150;
    localparam logic [15:0]        DEFAULT_WIDTH_MAX = 16'd23200;
    localparam logic [SCALE_W-1:0] DEFAULT_SCALE     = 18'd112394;
    localparam logic [DIST_W-1:0]  DEFAULT_DIST_MIN  = 16'd200;
    localparam logic [DIST_W-1:0]  DEFAULT_DIST_MAX  = 16'd40000;
    localparam logic [35:0]        ROUND_HALF        = 36'd32768;

    typedef struct packed {
        logic               kind;
        logic [CH_W-1:0]    ch;
        logic [15:0]        ticks;
        logic               ok;
        logic [DIST_W-1:0]  raw;
        logic [DIST_W-1:0]  filt;
        logic [COUNT_W-1:0] count;
        logic               all_done;
        logic               last;
    } t_range_report;

    logic [STAMP_W-1:0] rise_at     [CHANNELS];
    logic               in_pulse    [CHANNELS];
    logic               width_fresh [CHANNELS];
    logic [15:0]        width_ticks [CHANNELS];
    logic [COUNT_W-1:0] captures;
    logic [DIST_W-1:0]  samples     [CHANNELS][WINDOW];
    int                 fill_slot   [CHANNELS];
    logic               warmed      [CHANNELS];
    logic [DIST_W-1:0]  median_dist [CHANNELS];

    logic [15:0]        lim_wmin;
    logic [15:0]        lim_wmax;
    logic [SCALE_W-1:0] ticks_to_dist;
    logic [DIST_W-1:0]  lim_dmin;
    logic [DIST_W-1:0]  lim_dmax;

    t_range_report expected_reports [$];
    int failures = 0;

    assign o_failures = failures;

    task automatic note_failure(input string msg);
        $display("checker: %s", msg);
        failures++;
    endtask

    task automatic check_field(input string name, input logic [31:0] seen,
                               input logic [31:0] due, input logic [CH_W-1:0] ch);
        if (seen !== due)
            note_failure($sformatf("%s on channel %0d: got %0d, expected %0d",
                                   name, ch, seen, due));
    endtask

    task automatic reset_model();
        for (int k = 0; k < CHANNELS; k++) begin
            rise_at[k]     = '0;
            in_pulse[k]    = 1'b0;
            width_fresh[k] = 1'b0;
            width_ticks[k] = '0;
            fill_slot[k]   = 0;
            warmed[k]      = 1'b0;
            median_dist[k] = '0;
            for (int s = 0; s < WINDOW; s++)
                samples[k][s] = '0;
        end
        captures      = '0;
        lim_wmin      = DEFAULT_WIDTH_MIN;
        lim_wmax      = DEFAULT_WIDTH_MAX;
        ticks_to_dist = DEFAULT_SCALE;
        lim_dmin      = DEFAULT_DIST_MIN;
        lim_dmax      = DEFAULT_DIST_MAX;
        expected_reports.delete();
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_WIDTH_MIN:  lim_wmin      = val[15:0];
            CFG_WIDTH_MAX:  lim_wmax      = val[15:0];
            CFG_DIST_SCALE: ticks_to_dist = val[SCALE_W-1:0];
            CFG_DIST_MIN:   lim_dmin      = val[DIST_W-1:0];
            CFG_DIST_MAX:   lim_dmax      = val[DIST_W-1:0];
            default: ;
        endcase
    endtask

    // Median of the first cnt samples of a channel; with an even count the upper one wins.
    function automatic logic [DIST_W-1:0] window_median(input int ch, input int cnt);
        logic [DIST_W-1:0] sorted [WINDOW];
        logic [DIST_W-1:0] v;
        int j;
        for (int k = 0; k < cnt; k++) begin
            v = samples[ch][k];
            j = k;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[cnt/2];
    endfunction

    function automatic t_range_report make_report(input logic kind, input int ch,
                                                  input logic ok, input logic [DIST_W-1:0] raw,
                                                  input logic [DIST_W-1:0] filt,
                                                  input logic last);
        t_range_report r;
        r.kind     = kind;
        r.ch       = CH_W'(ch);
        r.ticks    = width_ticks[ch];
        r.ok       = ok;
        r.raw      = raw;
        r.filt     = filt;
        r.count    = captures;
        r.all_done = (int'(captures) >= CHANNELS);
        r.last     = last;
        return r;
    endfunction

    task automatic predict_item(input logic [1:0] act, input logic [CH_W-1:0] ch,
                                input logic [STAMP_W-1:0] st);
        logic [15:0]       w;
        logic [35:0]       product;
        logic [19:0]       range_cm;
        logic              ok;
        logic              good;
        logic [DIST_W-1:0] raw;
        logic [DIST_W-1:0] filt;
        int                s;
        case (act)
            ACT_ARM: begin
                for (int k = 0; k < CHANNELS; k++) begin
                    in_pulse[k]    = 1'b0;
                    width_fresh[k] = 1'b0;
                end
                captures = '0;
            end
            ACT_EDGE: begin
                if (int'(ch) < CHANNELS) begin
                    if (!in_pulse[ch]) begin
                        rise_at[ch]  = st;
                        in_pulse[ch] = 1'b1;
                    end else begin
                        // The subtraction wraps at the timer width on its own.
                        w = st - rise_at[ch];
                        width_ticks[ch] = w;
                        width_fresh[ch] = (w >= lim_wmin) && (w <= lim_wmax);
                        in_pulse[ch]    = 1'b0;
                        if (captures != '1)
                            captures++;
                    end
                    expected_reports.push_back(make_report(KIND_EDGE, int'(ch),
                        width_fresh[ch], '0, '0, 1'b1));
                end
            end
            ACT_FINISH: begin
                for (int i = 0; i < REPORTS; i++) begin
                    ok   = width_fresh[i];
                    good = 1'b0;
                    raw  = '0;
                    if (ok) begin
                        product  = 36'(width_ticks[i]) * 36'(ticks_to_dist) + ROUND_HALF;
                        range_cm = product[35:16];
                        // A zero distance is rejected even when the lower limit is zero.
                        if (range_cm != 0 && range_cm >= lim_dmin && range_cm <= lim_dmax) begin
                            good = 1'b1;
                            raw  = range_cm[DIST_W-1:0];
                        end
                    end
                    width_fresh[i] = 1'b0;
                    if (good) begin
                        s = fill_slot[i];
                        if (s >= WINDOW)
                            s = 0;
                        samples[i][s] = raw;
                        s++;
                        if (s >= WINDOW) begin
                            s = 0;
                            warmed[i] = 1'b1;
                        end
                        fill_slot[i]   = s;
                        median_dist[i] = window_median(i, warmed[i] ? WINDOW : s);
                    end else begin
                        median_dist[i] = '0;
                    end
                    // The held median is masked, not cleared, when the limits exclude it.
                    filt = median_dist[i];
                    if (filt < lim_dmin || filt > lim_dmax)
                        filt = '0;
                    expected_reports.push_back(make_report(KIND_REPORT, i, ok, raw, filt,
                                                           i == REPORTS - 1));
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_report();
        t_range_report got;
        t_range_report want;
        got.kind     = i_report_kind;
        got.ch       = i_channel_out;
        got.ticks    = i_pulse_ticks;
        got.ok       = i_pulse_ok;
        got.raw      = i_echo_range;
        got.filt     = i_median_range;
        got.count    = i_captured_count;
        got.all_done = i_all_captured;
        got.last     = i_last;
        if (expected_reports.size() == 0) begin
            note_failure($sformatf("result on channel %0d with nothing expected",
                                   i_channel_out));
        end else begin
            want = expected_reports.pop_front();
            check_field("report_kind", got.kind, want.kind, want.ch);
            check_field("channel_out", got.ch, want.ch, want.ch);
            check_field("pulse_ticks", got.ticks, want.ticks, want.ch);
            check_field("pulse_ok", got.ok, want.ok, want.ch);
            check_field("echo_range", got.raw, want.raw, want.ch);
            check_field("median_range", got.filt, want.filt, want.ch);
            check_field("captured_count", got.count, want.count, want.ch);
            check_field("all_captured", got.all_done, want.all_done, want.ch);
            check_field("last", got.last, want.last, want.ch);
        end
    endtask

    // A result is always older than an item taken in at the same edge, so compare first.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            o_pending <= 0;
        end else begin
            if (i_cfg_we)
                write_limit(i_cfg_index, i_cfg_data);
            if (i_out_valid && !i_out_stall)
                check_report();
            if (i_in_valid && !i_in_stall)
                predict_item(i_action, i_channel, i_stamp);
            o_pending <= expected_reports.size();
        end
    end

endmodule

[bench/multi_channel_echo_ranging_median_core_test.sv]
// Top of the echo ranging core testbench: clock, reset, stimulus, receiver stalls and verdict.
module multi_channel_echo_ranging_median_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcerm_pkg::*;

    localparam int          CHANNELS      = 8;
    localparam int          WINDOW        = 3;
    localparam int          TIMER_BITS    = 16;
    localparam int          LIMIT_CYCLES  = 300000;
    localparam int          SETTLE_CYCLES = 32;
    localparam int          RANDOM_ITEMS  = 276;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;

    typedef struct packed {
        logic [15:0]        wmin;
        logic [15:0]        wmax;
        logic [SCALE_W-1:0] scale;
        logic [DIST_W-1:0]  dmin;
        logic [DIST_W-1:0]  dmax;
    } t_limits;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic [1:0]            i_action    = '0;
    logic [CH_W-1:0]       i_channel   = '0;
    logic [STAMP_W-1:0]    i_stamp     = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_report_kind;
    logic [CH_W-1:0]       o_channel_out;
    logic [15:0]           o_pulse_ticks;
    logic                  o_pulse_ok;
    logic [DIST_W-1:0]     o_echo_range;
    logic [DIST_W-1:0]     o_median_range;
    logic [COUNT_W-1:0]    o_captured_count;
    logic                  o_all_captured;
    logic                  o_last;

    int          failures;
    int          pending;
    int          cycle_count = 0;
    int          items_done  = 0;
    int          burst_left  = 0;
    int          stall_left  = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    t_limits     cur         = '{16'd150, 16'd23200, 18'd112394, 16'd200, 16'd40000};

    multi_channel_echo_ranging_median_core #(
        .CHANNELS   (CHANNELS),
        .WINDOW     (WINDOW),
        .TIMER_BITS (TIMER_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_channel        (i_channel),
        .i_stamp          (i_stamp),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_report_kind    (o_report_kind),
        .o_channel_out    (o_channel_out),
        .o_pulse_ticks    (o_pulse_ticks),
        .o_pulse_ok       (o_pulse_ok),
        .o_echo_range     (o_echo_range),
        .o_median_range   (o_median_range),
        .o_captured_count (o_captured_count),
        .o_all_captured   (o_all_captured),
        .o_last           (o_last)
    );

    echo_ranging_checker #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_channel        (i_channel),
        .i_stamp          (i_stamp),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_report_kind    (o_report_kind),
        .i_channel_out    (o_channel_out),
        .i_pulse_ticks    (o_pulse_ticks),
        .i_pulse_ok       (o_pulse_ok),
        .i_echo_range     (o_echo_range),
        .i_median_range   (o_median_range),
        .i_captured_count (o_captured_count),
        .i_all_captured   (o_all_captured),
        .i_last           (o_last),
        .o_failures       (failures),
        .o_pending        (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[multi_channel_echo_ranging_median_core] ERROR");
            $finish;
        end
    end

    // The receiver switches at random between stall patterns: none, light, heavy and periodic.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 150);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ((cycle_count % 5) < 2);
        endcase
    end

    // Holds one item until its transfer; most bursts end in a random gap with valid low.
    task automatic send_item(input logic [1:0] act, input logic [CH_W-1:0] ch,
                             input logic [STAMP_W-1:0] st);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_channel  <= ch;
        i_stamp    <= st;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (act != ACT_UNUSED)
            items_done++;
    endtask

    // Arm items and ignored edges give no result, so a settle time follows the last one.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_limits(input t_limits lim);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WIDTH_MIN;
        i_cfg_data  <= CFG_DATA_W'(lim.wmin);
        @(posedge i_clk);
        i_cfg_index <= CFG_WIDTH_MAX;
        i_cfg_data  <= CFG_DATA_W'(lim.wmax);
        @(posedge i_clk);
        i_cfg_index <= CFG_DIST_SCALE;
        i_cfg_data  <= CFG_DATA_W'(lim.scale);
        @(posedge i_clk);
        i_cfg_index <= CFG_DIST_MIN;
        i_cfg_data  <= CFG_DATA_W'(lim.dmin);
        @(posedge i_clk);
        i_cfg_index <= CFG_DIST_MAX;
        i_cfg_data  <= CFG_DATA_W'(lim.dmax);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur = lim;
    endtask

    // Widths lean toward the accepted window and toward widths that land in the distance range.
    function automatic logic [15:0] pick_width();
        logic [33:0] w;
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 3))
                    0: return cur.wmin - 16'd1;
                    1: return cur.wmin;
                    2: return cur.wmax;
                    default: return cur.wmax + 16'd1;
                endcase
            end
            2: return 16'($urandom);
            3, 4, 5: begin
                if (cur.scale == '0)
                    return 16'($urandom);
                w = (34'($urandom_range(cur.dmin, cur.dmax)) << 16) / cur.scale;
                return (w > 34'hFFFF) ? 16'hFFFF : w[15:0];
            end
            default: return 16'($urandom_range(cur.wmin, cur.wmax));
        endcase
    endfunction

    // One measurement cycle: optional arm, edges on random channels in random order, finish.
    task automatic measure_cycle(input bit with_arm, input bit ragged);
        int                 edges_left [CHANNELS];
        int                 sent       [CHANNELS];
        logic [STAMP_W-1:0] start_at   [CHANNELS];
        int                 total;
        int                 c;
        total = 0;
        if (with_arm)
            send_item(ACT_ARM, CH_W'($urandom), STAMP_W'($urandom));
        for (int k = 0; k < CHANNELS; k++) begin
            sent[k]     = 0;
            start_at[k] = '0;
            if (ragged)
                edges_left[k] = $urandom_range(0, 3);
            else
                edges_left[k] = ($urandom_range(0, 4) != 0) ? 2 : 0;
            total += edges_left[k];
        end
        while (total > 0) begin
            c = $urandom_range(0, CHANNELS - 1);
            if (edges_left[c] != 0) begin
                if (sent[c] % 2 == 0) begin
                    start_at[c] = STAMP_W'($urandom);
                    send_item(ACT_EDGE, CH_W'(c), start_at[c]);
                end else begin
                    send_item(ACT_EDGE, CH_W'(c), start_at[c] + pick_width());
                end
                sent[c]++;
                edges_left[c]--;
                total--;
            end
        end
        send_item(ACT_FINISH, CH_W'($urandom), STAMP_W'($urandom));
    endtask

    task automatic random_phase(input int budget);
        int first_count;
        first_count = items_done;
        while (items_done - first_count < budget) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 4))
                       send_item(2'($urandom), CH_W'($urandom), STAMP_W'($urandom));
                // Several cycles without an arm can run the capture count into saturation.
                1: repeat (3) measure_cycle(1'b0, 1'b0);
                2: measure_cycle(1'b0, 1'b1);
                3: measure_cycle(1'b1, 1'b1);
                default: measure_cycle(1'b1, 1'b0);
            endcase
        end
    endtask

    task automatic directed_items();
        send_item(ACT_FINISH, 3'd0, 16'd0);
        send_item(ACT_ARM, 3'd0, 16'd0);
        send_item(ACT_EDGE, 3'd0, 16'd100);
        send_item(ACT_EDGE, 3'd0, 16'd250);      // exactly the shortest accepted pulse
        send_item(ACT_EDGE, 3'd1, 16'hFFF0);
        send_item(ACT_EDGE, 3'd1, 16'h0010);     // pulse across the timer wrap
        send_item(ACT_EDGE, 3'd2, 16'd0);
        send_item(ACT_EDGE, 3'd2, 16'd23200);    // exactly the longest accepted pulse
        send_item(ACT_EDGE, 3'd3, 16'd0);
        send_item(ACT_EDGE, 3'd3, 16'd23201);
        send_item(ACT_EDGE, 3'd4, 16'd5);
        send_item(ACT_EDGE, 3'd4, 16'd5);        // zero width
        send_item(ACT_EDGE, 3'd5, 16'hFFFF);
        send_item(ACT_EDGE, 3'd5, 16'hFFFE);     // widest pulse the timer can show
        send_item(ACT_EDGE, 3'd6, 16'd1000);
        send_item(ACT_EDGE, 3'd6, 16'd1149);
        send_item(ACT_EDGE, 3'd7, 16'd0);
        send_item(ACT_EDGE, 3'd7, 16'd1000);
        send_item(ACT_EDGE, 3'd7, 16'h5555);     // a new start left open at finish
        send_item(ACT_FINISH, 3'd7, 16'hFFFF);
        send_item(ACT_UNUSED, 3'd7, 16'hFFFF);
        send_item(ACT_FINISH, 3'd0, 16'd0);      // widths were consumed by the last finish
        send_item(ACT_ARM, 3'd5, 16'h1234);
        send_item(ACT_FINISH, 3'd2, 16'h4321);
    endtask

    initial begin
        t_limits phases [6];
        phases[0] = '{16'd0, 16'hFFFF, 18'h3FFFF, 16'd0, 16'hFFFF};
        phases[1] = '{16'hFFFF, 16'd0, 18'd0, 16'hFFFF, 16'd0};
        phases[2] = '{16'd1000, 16'd3000, 18'd65536, 16'd1500, 16'd2500};
        phases[3] = '{16'($urandom_range(0, 2000)), 16'($urandom_range(5000, 65535)),
                      18'($urandom), 16'($urandom_range(0, 1000)),
                      16'($urandom_range(20000, 65535))};
        phases[4] = '{16'($urandom_range(0, 2000)), 16'($urandom_range(5000, 65535)),
                      18'($urandom), 16'($urandom_range(0, 1000)),
                      16'($urandom_range(20000, 65535))};
        phases[5] = '{16'd150, 16'd23200, 18'd112394, 16'd200, 16'd40000};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_items();
        for (int p = 0; p < 6; p++) begin
            drain();
            apply_limits(phases[p]);
            random_phase(RANDOM_ITEMS / 6);
        end
        drain();
        if (failures == 0)
            $display("[multi_channel_echo_ranging_median_core] OK");
        else
            $display("[multi_channel_echo_ranging_median_core] ERROR");
        $finish;
    end

endmodule
